>>> rtl/core/rps_pkg.sv
package rps_pkg;

    // Scheduler sizing
    localparam int TASK_COUNT  = 32;
    localparam int IDLE_PRIO   = 31;
    localparam int LOWEST_PRIO = 31;
    localparam int NSLOTS      = 32;
    localparam int PRIO_W      = $clog2(NSLOTS);
    localparam int TICKS_W     = 16;

    typedef logic [PRIO_W-1:0]  t_prio;
    typedef logic [NSLOTS-1:0]  t_mask;
    typedef logic [TICKS_W-1:0] t_ticks;

    localparam t_prio LAST_P   = t_prio'(TASK_COUNT - 1);
    localparam t_prio IDLE_P   = t_prio'(IDLE_PRIO);
    localparam t_prio LOWEST_P = t_prio'(LOWEST_PRIO);

    // Operation codes
    typedef enum logic [2:0] {
        OP_CREATE    = 3'd0,
        OP_START     = 3'd1,
        OP_DELAY     = 3'd2,
        OP_TICK      = 3'd3,
        OP_IRQ_ENTER = 3'd4,
        OP_IRQ_EXIT  = 3'd5,
        OP_SCHEDULE  = 3'd6,
        OP_NOP       = 3'd7
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_INVALID     = 2'd1,
        STS_EXISTS      = 2'd2,
        STS_NOT_RUNNING = 2'd3
    } t_status;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_START  = 2'd1,
        ACT_SWITCH = 2'd2
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_TICK,
        S_TICK_END,
        S_DONE
    } t_state;

    // Sleep table access request
    typedef struct packed {
        logic   we;
        logic   clr;
        t_prio  waddr;
        t_ticks wdata;
        t_prio  raddr;
    } t_ram_req;

endpackage

>>> rtl/core/rps_sleep_ram.sv
module rps_sleep_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rps_pkg::t_ram_req   i_req,
    output rps_pkg::t_ticks     o_rd_data
);

    rps_pkg::t_ticks r_mem [rps_pkg::NSLOTS];
    rps_pkg::t_ticks r_rd_data;
    rps_pkg::t_mask  r_valid;
    logic            r_rd_valid;

    // Storage with one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    // Written flags: an entry never written (or cleared on create) reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end else if (i_req.clr) begin
                r_valid[i_req.waddr] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/core/rtos_priority_scheduler.sv
// Hardware ready-bitmap task scheduler.
// Input channel: i_valid / o_stall carry one operation (i_opcode, i_task_prio,
// i_delay_ticks, i_sched_locked); a transfer happens when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall carry exactly one result
// per operation (status, action and a snapshot of the scheduler state).
// One operation is in flight at a time; o_stall is high from the transfer
// until the result is loaded into the output register.
// A simple operation goes from S_EXEC straight to S_DONE; a ready scan runs
// S_SCAN before S_DONE, and a tick runs the S_TICK sweep and S_TICK_END. The
// next operation can be taken as soon as the result is loaded into the output
// register.
// The ready scan tests one priority bit per cycle, lowest number first, and
// stops at the first ready task; the tick sweeps the sleep table one entry
// per cycle through its one read port and one write port.
// A finished result may wait in the output register while the next operation
// is taken; if the receiver still stalls when that one finishes, the block
// holds it and keeps o_stall high.
// Reset (i_rst_n low, synchronous) leaves only the idle task created and
// ready, the scheduler not started, all counters at zero, o_valid low.
module rtos_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_task_prio,
    input  logic [15:0] i_delay_ticks,
    input  logic        i_sched_locked,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_action,
    output logic [4:0]  o_next_prio,
    output logic [4:0]  o_running_prio,
    output logic        o_switch_pending,
    output logic [7:0]  o_irq_depth,
    output logic [31:0] o_tick_total
);

    rps_pkg::t_state   r_state, n_state;
    rps_pkg::t_opcode  r_op, n_op;
    logic [7:0]        r_prio_in, n_prio_in;
    rps_pkg::t_ticks   r_ticks_in, n_ticks_in;
    logic              r_locked, n_locked;
    rps_pkg::t_mask    r_ready, n_ready;
    rps_pkg::t_mask    r_present, n_present;
    logic              r_started, n_started;
    rps_pkg::t_prio    r_cur, n_cur;
    rps_pkg::t_prio    r_high, n_high;
    logic [7:0]        r_nest, n_nest;
    logic              r_pending, n_pending;
    logic [31:0]       r_tick_count, n_tick_count;
    rps_pkg::t_prio    r_idx, n_idx;
    logic              r_scan_start, n_scan_start;
    logic              r_wb_go;
    rps_pkg::t_prio    r_wb_idx;
    rps_pkg::t_status  r_status, n_status;
    rps_pkg::t_action  r_action, n_action;

    logic              r_out_valid;
    rps_pkg::t_status  r_out_status;
    rps_pkg::t_action  r_out_action;
    rps_pkg::t_prio    r_out_next;
    rps_pkg::t_prio    r_out_run;
    logic              r_out_pending;
    logic [7:0]        r_out_depth;
    logic [31:0]       r_out_ticks;

    rps_pkg::t_ram_req w_req;
    rps_pkg::t_ticks   w_rd_data;
    logic              w_in_xfer;
    logic              w_out_load;
    logic              w_create_ok;
    logic              w_scan_hit;
    rps_pkg::t_prio    w_found;
    rps_pkg::t_prio    w_new_prio;

    rps_sleep_ram u_sleep_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    // Shared decode
    assign w_new_prio  = r_prio_in[rps_pkg::PRIO_W-1:0];
    assign w_create_ok = (r_prio_in < 8'(rps_pkg::TASK_COUNT)) && !r_present[w_new_prio];
    assign w_scan_hit  = r_ready[r_idx] || (r_idx == rps_pkg::LAST_P);
    assign w_found     = r_ready[r_idx] ? r_idx : rps_pkg::IDLE_P;

    // Sequencer outputs
    always_comb begin
        o_stall    = (r_state != rps_pkg::S_IDLE);
        w_in_xfer  = i_valid && (r_state == rps_pkg::S_IDLE);
        w_out_load = (r_state == rps_pkg::S_DONE) && (!r_out_valid || !i_stall);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rps_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = rps_pkg::S_EXEC;
                end
            end
            rps_pkg::S_EXEC: begin
                case (r_op)
                    rps_pkg::OP_CREATE: begin
                        n_state = (w_create_ok && r_started) ? rps_pkg::S_SCAN
                                                             : rps_pkg::S_DONE;
                    end
                    rps_pkg::OP_START: begin
                        n_state = r_started ? rps_pkg::S_DONE : rps_pkg::S_SCAN;
                    end
                    rps_pkg::OP_DELAY: begin
                        n_state = ((r_ticks_in != '0) && r_started) ? rps_pkg::S_SCAN
                                                                   : rps_pkg::S_DONE;
                    end
                    rps_pkg::OP_TICK: begin
                        n_state = rps_pkg::S_TICK;
                    end
                    rps_pkg::OP_IRQ_EXIT: begin
                        n_state = (r_nest == 8'd1) ? rps_pkg::S_SCAN : rps_pkg::S_DONE;
                    end
                    rps_pkg::OP_SCHEDULE: begin
                        n_state = rps_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = rps_pkg::S_DONE;
                    end
                endcase
            end
            rps_pkg::S_SCAN: begin
                if (w_scan_hit) begin
                    n_state = rps_pkg::S_DONE;
                end
            end
            rps_pkg::S_TICK: begin
                if (r_idx == rps_pkg::LAST_P) begin
                    n_state = rps_pkg::S_TICK_END;
                end
            end
            rps_pkg::S_TICK_END: begin
                n_state = rps_pkg::S_DONE;
            end
            rps_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = rps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rps_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_op         = r_op;
        n_prio_in    = r_prio_in;
        n_ticks_in   = r_ticks_in;
        n_locked     = r_locked;
        n_ready      = r_ready;
        n_present    = r_present;
        n_started    = r_started;
        n_cur        = r_cur;
        n_high       = r_high;
        n_nest       = r_nest;
        n_pending    = r_pending;
        n_tick_count = r_tick_count;
        n_idx        = r_idx;
        n_scan_start = r_scan_start;
        n_status     = r_status;
        n_action     = r_action;
        w_req        = '0;
        w_req.raddr  = r_idx;

        // Tick write-back: decrement a present, nonzero entry; ready it on expiry
        if (r_wb_go && r_present[r_wb_idx] && (w_rd_data != '0)) begin
            w_req.we    = 1'b1;
            w_req.waddr = r_wb_idx;
            w_req.wdata = w_rd_data - rps_pkg::t_ticks'(1);
            if (w_rd_data == rps_pkg::t_ticks'(1)) begin
                n_ready[r_wb_idx] = 1'b1;
            end
        end

        case (r_state)
            rps_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_op       = rps_pkg::t_opcode'(i_opcode);
                    n_prio_in  = i_task_prio;
                    n_ticks_in = i_delay_ticks;
                    n_locked   = i_sched_locked;
                    n_status   = rps_pkg::STS_OK;
                    n_action   = rps_pkg::ACT_NONE;
                    n_idx      = '0;
                    n_scan_start = 1'b0;
                end
            end
            rps_pkg::S_EXEC: begin
                case (r_op)
                    rps_pkg::OP_CREATE: begin
                        if (r_prio_in >= 8'(rps_pkg::TASK_COUNT)) begin
                            n_status = rps_pkg::STS_INVALID;
                        end else if (r_present[w_new_prio]) begin
                            n_status = rps_pkg::STS_EXISTS;
                        end else begin
                            n_present[w_new_prio] = 1'b1;
                            n_ready[w_new_prio]   = 1'b1;
                            w_req.clr             = 1'b1;
                            w_req.waddr           = w_new_prio;
                            if (w_new_prio < r_high) begin
                                n_high = w_new_prio;
                            end
                        end
                    end
                    rps_pkg::OP_START: begin
                        if (!r_started) begin
                            n_started    = 1'b1;
                            n_scan_start = 1'b1;
                        end
                    end
                    rps_pkg::OP_DELAY: begin
                        if (r_ticks_in != '0) begin
                            if (!r_started) begin
                                n_status = rps_pkg::STS_NOT_RUNNING;
                            end else begin
                                w_req.we       = 1'b1;
                                w_req.waddr    = r_cur;
                                w_req.wdata    = r_ticks_in;
                                n_ready[r_cur] = 1'b0;
                            end
                        end
                    end
                    rps_pkg::OP_TICK: begin
                        n_tick_count = r_tick_count + 32'd1;
                    end
                    rps_pkg::OP_IRQ_ENTER: begin
                        if (r_nest != 8'hFF) begin
                            n_nest = r_nest + 8'd1;
                        end
                    end
                    rps_pkg::OP_IRQ_EXIT: begin
                        if (r_nest != 8'd0) begin
                            n_nest = r_nest - 8'd1;
                        end
                    end
                    rps_pkg::OP_SCHEDULE: begin
                        if (!r_started) begin
                            n_status = rps_pkg::STS_NOT_RUNNING;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // One priority bit per cycle; the first ready one wins
            rps_pkg::S_SCAN: begin
                n_idx = r_idx + rps_pkg::t_prio'(1);
                if (w_scan_hit) begin
                    n_high = w_found;
                    if (r_scan_start) begin
                        n_cur     = w_found;
                        n_pending = 1'b0;
                        n_action  = rps_pkg::ACT_START;
                    end else if (r_started && (w_found != r_cur)) begin
                        if ((r_nest == 8'd0) && !r_locked) begin
                            n_cur     = w_found;
                            n_pending = 1'b0;
                            n_action  = rps_pkg::ACT_SWITCH;
                        end else begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            // Sweep issues one sleep-table read per cycle
            rps_pkg::S_TICK: begin
                n_idx = r_idx + rps_pkg::t_prio'(1);
            end
            default: begin
            end
        endcase
    end

    // Control and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rps_pkg::S_IDLE;
            r_ready      <= rps_pkg::t_mask'(1) << rps_pkg::IDLE_P;
            r_present    <= rps_pkg::t_mask'(1) << rps_pkg::IDLE_P;
            r_started    <= 1'b0;
            r_cur        <= rps_pkg::LOWEST_P;
            r_high       <= rps_pkg::IDLE_P;
            r_nest       <= 8'd0;
            r_pending    <= 1'b0;
            r_tick_count <= 32'd0;
            r_wb_go      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ready      <= n_ready;
            r_present    <= n_present;
            r_started    <= n_started;
            r_cur        <= n_cur;
            r_high       <= n_high;
            r_nest       <= n_nest;
            r_pending    <= n_pending;
            r_tick_count <= n_tick_count;
            r_wb_go      <= (r_state == rps_pkg::S_TICK);
        end
    end

    // Operation payload and sequencer working registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_prio_in    <= n_prio_in;
        r_ticks_in   <= n_ticks_in;
        r_locked     <= n_locked;
        r_idx        <= n_idx;
        r_scan_start <= n_scan_start;
        r_wb_idx     <= r_idx;
        r_status     <= n_status;
        r_action     <= n_action;
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status  <= r_status;
            r_out_action  <= r_action;
            r_out_next    <= r_high;
            r_out_run     <= r_cur;
            r_out_pending <= r_pending;
            r_out_depth   <= r_nest;
            r_out_ticks   <= r_tick_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_action         = r_out_action;
    assign o_next_prio      = r_out_next;
    assign o_running_prio   = r_out_run;
    assign o_switch_pending = r_out_pending;
    assign o_irq_depth      = r_out_depth;
    assign o_tick_total     = r_out_ticks;

    // Once started, the running task always exists
    a_cur_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_present[r_cur])
        else $error("running priority is not a created task");

    // Tick counter moves only when a tick operation executes
    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_tick_count != $past(r_tick_count)))
        |-> ($past(r_state) == rps_pkg::S_EXEC && $past(r_op) == rps_pkg::OP_TICK))
        else $error("tick counter changed outside a tick");

    // Sleep-table write-back happens only inside the tick sweep
    a_wb_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_go |-> (r_state == rps_pkg::S_TICK || r_state == rps_pkg::S_TICK_END))
        else $error("tick write-back outside the sweep");

    // An issued switch leaves nothing pending
    a_switch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_action == rps_pkg::ACT_SWITCH)
        |-> (!r_out_pending && r_out_run == r_out_next))
        else $error("switch reported with pending flag or stale running task");

endmodule
